@@ rtl/mka_pkg.sv @@
// ----------------------------------------------------------------------------
// mka_pkg
// Shared types and constants for the multi-key argmax block.
// ----------------------------------------------------------------------------
package mka_pkg;

  localparam int WORD_W      = 64;
  localparam int COORD_W     = 24;
  localparam int WT_W        = 16;
  localparam int HT_W        = 16;
  localparam int IDX_OUT_W   = 10;
  localparam int CNT_OUT_W   = 11;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 24;
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 48;
  localparam int PCNT_W      = 6;

  typedef enum logic [1:0] {
    MODE_WORD   = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_RATIO  = 2'd2,
    MODE_POPCNT = 2'd3
  } key_mode_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;     // capture the input item
    logic       mul_en;   // run one multiplier step
    logic [1:0] step;     // which multiplier step
    logic       decide;   // compare and update the running best
  } mka_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip_mul;  // key needs no multiplier, or item is past the depth
    logic last;      // captured item ends the set
    logic out_busy;  // result slot full and not being taken this cycle
  } mka_sts_t;

endpackage

@@ rtl/multi_key_argmax.sv @@
// ----------------------------------------------------------------------------
// multi_key_argmax
// Streaming argmax over a marked set of elements with a selectable key.
// ----------------------------------------------------------------------------
// Each element is taken in the idle state, then walks up to four
// multiplier steps through the single shared 32x32 multiplier in modes 1
// (squared point length) and 2 (weight over height squared); in modes 0
// (word) and 3 (popcount), and past the depth limit, the sequence ends
// early. A compare/update step follows. A set-end result sits in an output
// register, so the next element is accepted while it waits; the compare of
// the following set end holds until that register is empty or being taken.
// key_mode should be written only between elements.
module multi_key_argmax #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_data,   // key_mode
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // word[63:0], coord_x[87:64], coord_y[111:88], coord_z[135:112],
  // weight[151:136], height[167:152]
  input  logic [mka_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 in_tlast,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // max_index[9:0], element_count[20:10], overflow[21], zero[23:22]
  output logic [mka_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import mka_pkg::*;

  mka_cmd_t               cmd;
  mka_sts_t               sts;
  logic [IDX_OUT_W-1:0]   max_index;
  logic [CNT_OUT_W-1:0]   element_count;
  logic                   overflow;

  assign cfg_ready = 1'b1;

  mka_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mka_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .in_word           (in_tdata[63:0]),
    .in_coord_x        (in_tdata[87:64]),
    .in_coord_y        (in_tdata[111:88]),
    .in_coord_z        (in_tdata[135:112]),
    .in_weight         (in_tdata[151:136]),
    .in_height         (in_tdata[167:152]),
    .in_last           (in_tlast),
    .cmd               (cmd),
    .sts               (sts),
    .out_tready        (out_tready),
    .out_valid         (out_tvalid),
    .out_max_index     (max_index),
    .out_element_count (element_count),
    .out_overflow      (overflow)
  );

  assign out_tdata = {2'b00, overflow, element_count, max_index};

endmodule

@@ rtl/mka_ctrl.sv @@
// ----------------------------------------------------------------------------
// mka_ctrl
// Sequencer: accepts an item, walks the multiplier steps, then issues the
// compare/update, holding it at a set end until the result slot can take the result.
// ----------------------------------------------------------------------------
module mka_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output mka_pkg::mka_cmd_t cmd,
  input  mka_pkg::mka_sts_t sts
);
  import mka_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MUL  = 2'd1,
    S_DEC  = 2'd2
  } state_t;

  state_t     state_r;
  logic [1:0] step_r;
  logic       dec_go;

  assign dec_go    = !(sts.last && sts.out_busy);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_tvalid;
    cmd.mul_en = (state_r == S_MUL);
    cmd.step   = step_r;
    cmd.decide = (state_r == S_DEC) && dec_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 2'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_MUL;
            step_r  <= 2'd0;
          end
        end
        S_MUL: begin
          if (sts.skip_mul || step_r == 2'd3) begin
            state_r <= S_DEC;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        S_DEC: begin
          if (dec_go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous one still in flight");

  a_last_step_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) && (step_r == 2'd3) |=> (state_r == S_DEC))
    else $error("multiplier sequence did not end in compare");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.mul_en && !cmd.decide)
    else $error("datapath commanded while idle");
`endif

endmodule

@@ rtl/mka_dpath.sv @@
// ----------------------------------------------------------------------------
// mka_dpath
// Item registers, shared 32x32 multiplier, key compare, running best and
// the result register.
// ----------------------------------------------------------------------------
module mka_dpath #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_data,
  input  logic [mka_pkg::WORD_W-1:0]        in_word,
  input  logic signed [mka_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [mka_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [mka_pkg::COORD_W-1:0] in_coord_z,
  input  logic [mka_pkg::WT_W-1:0]          in_weight,
  input  logic [mka_pkg::HT_W-1:0]          in_height,
  input  logic                              in_last,
  input  mka_pkg::mka_cmd_t                 cmd,
  output mka_pkg::mka_sts_t                 sts,
  input  logic                              out_tready,
  output logic                              out_valid,
  output logic [mka_pkg::IDX_OUT_W-1:0]     out_max_index,
  output logic [mka_pkg::CNT_OUT_W-1:0]     out_element_count,
  output logic                              out_overflow
);
  import mka_pkg::*;

  localparam int IDX_W   = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int POS_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_EXT = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
  localparam int CNT_EXT = (POS_W > CNT_OUT_W) ? POS_W : CNT_OUT_W;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) n = n + 4'(v[b]);
    return n;
  endfunction

  key_mode_t              mode_r;

  // captured item
  logic [WORD_W-1:0]      word_r;
  logic [COORD_W-1:0]     ax_r, ay_r, az_r;
  logic [WT_W-1:0]        w_r;
  logic [HT_W-1:0]        h_r;
  logic                   last_r;
  logic [PCNT_W-1:0]      pc_r;

  // multiplier
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [2*MUL_W-1:0]     mul_p;
  logic [PROD_W-1:0]      prod_r, t_r;

  // running best
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [WORD_W-1:0]      best_key_r, best_key_nxt;
  logic [WT_W-1:0]        best_w_r, best_w_nxt;
  logic [HT_W-1:0]        best_h_r, best_h_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   out_valid_r;
  logic [IDX_OUT_W-1:0]   out_idx_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;
  logic                   out_ovf_r;

  logic                   ovf_cond;
  logic [WORD_W-1:0]      key;
  logic                   ratio_gt, greater;
  logic [IDX_EXT-1:0]     idx_ext;
  logic [CNT_EXT-1:0]     cnt_ext;
  logic [PCNT_W-1:0]      pc_in;

  assign ovf_cond = (pos_r >= POS_W'(MAX_ELEMENTS));
  assign pc_in    = PCNT_W'(ones8(in_word[7:0])) + PCNT_W'(ones8(in_word[15:8]))
                  + PCNT_W'(ones8(in_word[23:16])) + PCNT_W'(ones8(in_word[31:24]));

  assign sts.skip_mul = ovf_cond || (mode_r == MODE_WORD) || (mode_r == MODE_POPCNT);
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && !out_tready;

  // Operand schedule. Point: x^2, y^2, z^2 summed into t_r.
  // Ratio: h^2, bh^2, bw*h^2 (lands in t_r), w*bh^2 (lands in prod_r).
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (mode_r == MODE_RATIO) begin
      unique case (cmd.step)
        2'd0: begin mul_a = MUL_W'(h_r);      mul_b = MUL_W'(h_r);      end
        2'd1: begin mul_a = MUL_W'(best_h_r); mul_b = MUL_W'(best_h_r); end
        2'd2: begin mul_a = MUL_W'(best_w_r); mul_b = t_r[MUL_W-1:0];   end
        default: begin mul_a = MUL_W'(w_r);   mul_b = t_r[MUL_W-1:0];   end
      endcase
    end else begin
      unique case (cmd.step)
        2'd0: begin mul_a = MUL_W'(ax_r); mul_b = MUL_W'(ax_r); end
        2'd1: begin mul_a = MUL_W'(ay_r); mul_b = MUL_W'(ay_r); end
        2'd2: begin mul_a = MUL_W'(az_r); mul_b = MUL_W'(az_r); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (mode_r)
      MODE_WORD:   key = word_r;
      MODE_POINT:  key = WORD_W'(t_r);
      MODE_RATIO:  key = '0;
      MODE_POPCNT: key = WORD_W'(pc_r);
      default:     key = '0;
    endcase
  end

  // zero height is an infinite ratio; two infinities tie
  always_comb begin
    priority if (h_r == '0) ratio_gt = (best_h_r != '0);
    else if (best_h_r == '0) ratio_gt = 1'b0;
    else ratio_gt = (prod_r > t_r);
  end

  always_comb begin
    priority if (pos_r == '0) greater = 1'b1;
    else if (mode_r == MODE_RATIO) greater = ratio_gt;
    else greater = (key > best_key_r);
  end

  always_comb begin
    pos_nxt      = pos_r;
    best_idx_nxt = best_idx_r;
    best_key_nxt = best_key_r;
    best_w_nxt   = best_w_r;
    best_h_nxt   = best_h_r;
    ovf_nxt      = ovf_r;
    if (ovf_cond) begin
      ovf_nxt = 1'b1;
    end else begin
      if (greater) begin
        best_idx_nxt = pos_r[IDX_W-1:0];
        best_key_nxt = key;
        best_w_nxt   = w_r;
        best_h_nxt   = h_r;
      end
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign idx_ext = IDX_EXT'(best_idx_nxt);
  assign cnt_ext = CNT_EXT'(pos_nxt);

  // configuration and item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WORD;
    end else if (cfg_valid) begin
      mode_r <= key_mode_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_word;
      ax_r   <= in_coord_x[COORD_W-1] ? COORD_W'(-in_coord_x) : COORD_W'(in_coord_x);
      ay_r   <= in_coord_y[COORD_W-1] ? COORD_W'(-in_coord_y) : COORD_W'(in_coord_y);
      az_r   <= in_coord_z[COORD_W-1] ? COORD_W'(-in_coord_z) : COORD_W'(in_coord_z);
      w_r    <= in_weight;
      h_r    <= in_height;
      pc_r   <= pc_in;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p[PROD_W-1:0];
      if (cmd.step == 2'd0) begin
        t_r <= '0;
      end else if (mode_r == MODE_RATIO) begin
        t_r <= prod_r;
      end else begin
        t_r <= t_r + prod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (cmd.load) begin
      last_r <= in_last;
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      best_idx_r <= '0;
      best_key_r <= '0;
      best_w_r   <= '0;
      best_h_r   <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.decide) begin
      if (last_r) begin
        pos_r      <= '0;
        best_idx_r <= '0;
        best_key_r <= '0;
        best_w_r   <= '0;
        best_h_r   <= '0;
        ovf_r      <= 1'b0;
      end else begin
        pos_r      <= pos_nxt;
        best_idx_r <= best_idx_nxt;
        best_key_r <= best_key_nxt;
        best_w_r   <= best_w_nxt;
        best_h_r   <= best_h_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && last_r) begin
      out_idx_r <= idx_ext[IDX_OUT_W-1:0];
      out_cnt_r <= cnt_ext[CNT_OUT_W-1:0];
      out_ovf_r <= ovf_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_max_index     = out_idx_r;
  assign out_element_count = out_cnt_r;
  assign out_overflow      = out_ovf_r;

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_ELEMENTS))
    else $error("element position past depth");

  a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide && last_r |=> (pos_r == '0) && !ovf_r)
    else $error("set state not cleared after set end");

  a_ovf_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (pos_r == POS_W'(MAX_ELEMENTS)))
    else $error("overflow flagged below depth");
`endif

endmodule

@@ test/multi_key_argmax_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_key_argmax_test
// Self-checking bench for the streaming argmax block. Sets of elements are
// driven under all four key modes. A local predictor tracks the running best
// and queues one expected result per set end. The monitor compares every
// result transfer with that queue. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module multi_key_argmax_test;
  import mka_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int SETTLE      = 20;    // cycles for an element still in flight
  localparam int RAND_TARGET = 650;

  typedef struct {
    logic [63:0]        word;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [15:0]        weight;
    logic [15:0]        height;
    bit                 last;
  } elem_t;

  typedef struct {
    logic [9:0]  max_index;
    logic [10:0] count;
    logic        ovf;
  } set_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_data = 2'd0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // word, coord_x, coord_y, coord_z, weight, height
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // max_index, element_count, overflow, zero pad

  elem_t       pending_elems[$];
  set_result_t expected_sets[$];
  elem_t       drv_elem;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          calm = 1'b0;
  int          errors = 0;
  int          elems_taken = 0;
  int          sets_checked = 0;
  int          ovf_sets = 0;
  int          mode_writes = 0;

  // predictor state
  key_mode_t         cur_mode = MODE_WORD;
  int                best_pos = 0;
  int                set_pos = 0;
  longint unsigned   best_key = 0;
  logic [15:0]       best_w = '0;
  logic [15:0]       best_h = '0;
  bit                set_ovf = 1'b0;

  multi_key_argmax #(.MAX_ELEMENTS(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Running argmax update for one element; returns 1 when the set closes.
  function automatic bit argmax_step(input elem_t e, output set_result_t r);
    longint unsigned key;
    longint          sx, sy, sz;
    longint unsigned lhs, rhs;
    bit              greater;
    key = 0;
    sx = e.cx;
    sy = e.cy;
    sz = e.cz;
    case (cur_mode)
      MODE_WORD:   key = e.word;
      MODE_POINT:  key = sx * sx + sy * sy + sz * sz;
      MODE_POPCNT: key = $countones(e.word[31:0]);
      default:     key = 0;
    endcase
    if (set_pos >= DEPTH) begin
      set_ovf = 1'b1;
    end else begin
      if (set_pos == 0) begin
        greater = 1'b1;
      end else if (cur_mode == MODE_RATIO) begin
        // zero height is an infinite ratio; two infinities tie
        if (e.height == 0) begin
          greater = (best_h != 0);
        end else if (best_h == 0) begin
          greater = 1'b0;
        end else begin
          lhs = 64'(e.weight) * (64'(best_h) * 64'(best_h));
          rhs = 64'(best_w) * (64'(e.height) * 64'(e.height));
          greater = lhs > rhs;
        end
      end else begin
        greater = key > best_key;
      end
      if (greater) begin
        best_pos = set_pos;
        best_key = key;
        best_w = e.weight;
        best_h = e.height;
      end
      set_pos++;
    end
    r.max_index = best_pos[9:0];
    r.count = set_pos[10:0];
    r.ovf = set_ovf;
    if (!e.last) return 1'b0;
    best_pos = 0;
    set_pos = 0;
    best_key = 0;
    best_w = '0;
    best_h = '0;
    set_ovf = 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // handshake observation and result checking
  always @(posedge clk) begin : observe
    set_result_t want, got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) cur_mode = key_mode_t'(cfg_data);
      if (in_tvalid && in_tready) begin
        elems_taken++;
        if (argmax_step(drv_elem, want)) expected_sets.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.max_index = out_tdata[9:0];
        got.count = out_tdata[20:10];
        got.ovf = out_tdata[21];
        if (expected_sets.size() == 0) begin
          flag_mismatch($sformatf("unexpected result idx=%0d cnt=%0d ovf=%0d",
                                  got.max_index, got.count, got.ovf));
        end else begin
          want = expected_sets.pop_front();
          sets_checked++;
          if (want.ovf) ovf_sets++;
          if (got.max_index !== want.max_index || got.count !== want.count ||
              got.ovf !== want.ovf)
            flag_mismatch($sformatf("set %0d: idx %0d/%0d cnt %0d/%0d ovf %0d/%0d (got/want)",
                                    sets_checked, got.max_index, want.max_index,
                                    got.count, want.count, got.ovf, want.ovf));
        end
      end
    end
    in_fire <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
  end

  // element driver
  always @(negedge clk) begin : drive_elems
    elem_t e;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_elems.size() > 0) begin
        e = pending_elems.pop_front();
        drv_elem <= e;
        in_tdata <= {e.height, e.weight, e.cz, e.cy, e.cx, e.word};
        in_tlast <= e.last;
        in_tvalid <= 1'b1;
        in_gap <= draw_wait();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin : drive_ready
    int s;
    s = out_fire ? draw_wait() : out_stall;
    if (s > 0) begin
      out_tready <= 1'b0;
      out_stall <= s - 1;
    end else begin
      out_tready <= 1'b1;
      out_stall <= 0;
    end
  end

  function automatic elem_t mk(logic [63:0] word, int x, int y, int z, int w, int h,
                               bit last);
    elem_t e;
    e.word = word;
    e.cx = 24'(x);
    e.cy = 24'(y);
    e.cz = 24'(z);
    e.weight = 16'(w);
    e.height = 16'(h);
    e.last = last;
    return e;
  endfunction

  // Random content, biased toward ties, zero heights and field extremes.
  function automatic elem_t rand_elem(input elem_t prev, input bit last);
    elem_t e;
    e.word = {$urandom(), $urandom()};
    e.cx = 24'($urandom());
    e.cy = 24'($urandom());
    e.cz = 24'($urandom());
    e.weight = 16'($urandom());
    e.height = 16'($urandom());
    case ($urandom_range(0, 7))
      0: e.word = prev.word;
      1: e.word = 64'($urandom_range(0, 255));
      2: e.word = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: begin
        e.cx = prev.cx;
        e.cy = prev.cy;
        e.cz = prev.cz;
      end
      1: begin
        // sign flip keeps the squared length
        e.cx = -prev.cx;
        e.cy = -prev.cy;
        e.cz = prev.cz;
      end
      2: begin
        e.cx = 24'($urandom_range(0, 15));
        e.cy = 24'(-$urandom_range(0, 15));
        e.cz = 0;
      end
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: e.height = 0;
      1: e.height = 16'($urandom_range(1, 300));
      2: begin
        e.height = prev.height;
        e.weight = prev.weight;
      end
      default: ;
    endcase
    e.last = last;
    return e;
  endfunction

  task automatic wait_idle();
    while (pending_elems.size() != 0 || in_tvalid || expected_sets.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input key_mode_t m);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  initial begin : stimulus
    elem_t     prev;
    key_mode_t m;
    int        rand_sent, phase, n, k, sz;
    bit        cut;
    rand_sent = 0;
    phase = 0;
    prev = mk(0, 0, 0, 0, 0, 0, 1'b0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // word key: extremes and a tie on the maximum, then a one-element set
    write_mode(MODE_WORD);
    pending_elems.push_back(mk(64'd0, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk('1, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk('1, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk(64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 1'b1));
    pending_elems.push_back(mk(64'd0, 0, 0, 0, 0, 0, 1'b1));

    // point key: most negative corner beats most positive, tie kept
    write_mode(MODE_POINT);
    pending_elems.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk(0, -8388608, -8388608, -8388608, 0, 0, 1'b0));
    pending_elems.push_back(mk(0, 8388607, 8388607, 8388607, 0, 0, 1'b0));
    pending_elems.push_back(mk(0, -8388608, -8388608, -8388608, 0, 0, 1'b1));

    // ratio key: zero height wins, a second zero height ties
    write_mode(MODE_RATIO);
    pending_elems.push_back(mk(0, 0, 0, 0, 64, 170, 1'b0));
    pending_elems.push_back(mk(0, 0, 0, 0, 65535, 65535, 1'b0));
    pending_elems.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk(0, 0, 0, 0, 65535, 0, 1'b1));
    pending_elems.push_back(mk(0, 0, 0, 0, 5, 0, 1'b0));
    pending_elems.push_back(mk(0, 0, 0, 0, 9, 0, 1'b1));

    // popcount: upper half ignored, bit 31 counted
    write_mode(MODE_POPCNT);
    pending_elems.push_back(mk(64'hFFFF_FFFF_0000_0000, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk(64'h7FFF_FFFF, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk(64'hFFFF_FFFF, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk(64'h1_FFFF_FFFF, 0, 0, 0, 0, 0, 1'b1));

    // key mode switched with a set open
    pending_elems.push_back(mk(64'h1F, 0, 0, 0, 0, 0, 1'b0));
    write_mode(MODE_WORD);
    pending_elems.push_back(mk(64'h10, 0, 0, 0, 0, 0, 1'b0));
    pending_elems.push_back(mk(64'h3, 0, 0, 0, 0, 0, 1'b1));
    pending_elems.push_back(mk(64'h5, 0, 0, 0, 10, 100, 1'b0));
    write_mode(MODE_RATIO);
    pending_elems.push_back(mk(64'h0, 0, 0, 0, 20, 100, 1'b1));

    // over-depth set: best sits at the last slot, extra elements ignored
    write_mode(MODE_WORD);
    for (int i = 0; i < DEPTH + 2; i++)
      pending_elems.push_back(mk((i >= DEPTH - 1) ? '1 : {1'b0, 31'($urandom()), $urandom()},
                                 0, 0, 0, 0, 0, i == DEPTH + 1));

    // random sets, phases end at random mid-set so the mode changes inside a set
    while (rand_sent < RAND_TARGET) begin
      m = (phase < 4) ? key_mode_t'(phase) : key_mode_t'($urandom_range(0, 3));
      write_mode(m);
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(30, 80);
      k = 0;
      while (k < n) begin
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        cut = (k + sz >= n) && ($urandom_range(0, 2) == 0);
        for (int i = 0; i < sz; i++) begin
          prev = rand_elem(prev, (i == sz - 1) && !cut);
          pending_elems.push_back(prev);
        end
        k += sz;
      end
      rand_sent += k;
      phase++;
    end
    calm = 1'b0;
    if (!prev.last) pending_elems.push_back(rand_elem(prev, 1'b1));

    while (pending_elems.size() != 0 || in_tvalid || expected_sets.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
    $display("run: %0d elements in %0d sets, %0d key mode writes over all four keys",
             elems_taken, sets_checked, mode_writes);
    $display("run: %0d over-depth set(s), ties, zero heights and mid-set mode changes",
             ovf_sets);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_sets.size());
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/mka_pkg.sv
rtl/mka_ctrl.sv
rtl/mka_dpath.sv
rtl/multi_key_argmax.sv
test/multi_key_argmax_test.sv
